/* src/tcfr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfr_pkg
// Types and constants for the nine-byte motor command framer and reply
// checker.
// ----------------------------------------------------------------------------
package tcfr_pkg;

    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned FRAME_LEN  = 9;

    localparam logic [3:0] SUM_LEN    = 4'd8;
    localparam logic [3:0] STATUS_POS = 4'd2;
    localparam logic [3:0] VALUE_POS  = 4'd4;
    localparam logic [3:0] LAST_IDX   = 4'd8;
    localparam logic [9:0] TICKS_MAX  = 10'h3FF;

    localparam logic [7:0] RST_CODE_RIGHT = 8'd1;
    localparam logic [7:0] RST_CODE_LEFT  = 8'd2;
    localparam logic [7:0] RST_CODE_STOP  = 8'd3;
    localparam logic [7:0] RST_ACK        = 8'd100;
    localparam logic [9:0] RST_TIMEOUT    = 10'd50;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_RX_BYTE = 2'd1,
        OP_TICK    = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        MOTION_RIGHT = 2'd0,
        MOTION_LEFT  = 2'd1,
        MOTION_STOP  = 2'd2
    } motion_t;

    typedef enum logic [2:0] {
        KIND_TX       = 3'd0,
        KIND_OK       = 3'd1,
        KIND_NACK     = 3'd2,
        KIND_CSUM_ERR = 3'd3,
        KIND_TIMEOUT  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        REG_CODE_RIGHT = 3'd0,
        REG_CODE_LEFT  = 3'd1,
        REG_CODE_STOP  = 3'd2,
        REG_ACK        = 3'd3,
        REG_TIMEOUT    = 3'd4
    } reg_index_t;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [7:0]         module_address;
        logic [1:0]         motion;
        logic signed [31:0] velocity;
        logic               read_back;
        logic [7:0]         rx_byte;
    } req_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [7:0]         tx_byte;
        logic               tx_last;
        logic [7:0]         reply_status;
        logic signed [31:0] reply_value;
    } res_t;

    typedef struct packed {
        logic [7:0] code_rotate_right;
        logic [7:0] code_rotate_left;
        logic [7:0] code_stop;
        logic [7:0] ack_status_code;
        logic [9:0] timeout_ticks;
    } cfg_t;

    typedef struct packed {
        logic                         is_frame;
        byte_t [FRAME_LEN-1:0]        frame;
        logic [2:0]                   kind;
        logic [7:0]                   status;
        logic [31:0]                  value;
    } job_t;

endpackage

/* src/tcfr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfr_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface tcfr_req_if;
    logic            valid;
    logic            ready;
    tcfr_pkg::req_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tcfr_res_if;
    logic            valid;
    logic            ready;
    tcfr_pkg::res_t  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/tcfr_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfr_engine
// Request register, command framing and reply receiver state; hands one
// job per request that yields results to the serialiser.
// ----------------------------------------------------------------------------
module tcfr_engine
(
    input  logic                clk,
    input  logic                rst_n,
    tcfr_req_if.sink            request,
    input  tcfr_pkg::cfg_t      cfg,
    input  logic                job_free,
    output logic                job_valid,
    output tcfr_pkg::job_t      job
);

    logic            req_valid_reg;
    logic            req_valid_next;
    tcfr_pkg::req_t  req_reg;
    logic            go;

    logic            armed_reg;
    logic            armed_next;
    logic [3:0]      reply_count_reg;
    logic [3:0]      reply_count_next;
    logic [7:0]      reply_sum_reg;
    logic [7:0]      reply_sum_next;
    logic [7:0]      held_status_reg;
    logic [7:0]      held_status_next;
    logic [31:0]     held_value_reg;
    logic [31:0]     held_value_next;
    logic [9:0]      elapsed_reg;
    logic [9:0]      elapsed_next;

    logic            neg;
    logic [31:0]     mag;
    logic [7:0]      code;
    logic [31:0]     value;
    logic [7:0]      sum;
    tcfr_pkg::byte_t [tcfr_pkg::FRAME_LEN-1:0] frame;

    assign go            = req_valid_reg && job_free;
    assign request.ready = !req_valid_reg || go;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (request.valid && request.ready)
        begin
            req_valid_next = 1'b1;
        end
        else if (go)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (request.valid && request.ready)
        begin
            req_reg <= request.data;
        end
    end

    // build the command frame
    always_comb
    begin
        neg = req_reg.velocity[31];
        mag = neg ? (32'd0 - 32'(req_reg.velocity)) : 32'(req_reg.velocity);
        case (req_reg.motion)
            tcfr_pkg::MOTION_RIGHT:
            begin
                code  = neg ? cfg.code_rotate_left : cfg.code_rotate_right;
                value = mag;
            end
            tcfr_pkg::MOTION_LEFT:
            begin
                code  = neg ? cfg.code_rotate_right : cfg.code_rotate_left;
                value = mag;
            end
            default:
            begin
                code  = cfg.code_stop;
                value = 32'd0;
            end
        endcase
        frame[0] = req_reg.module_address;
        frame[1] = code;
        frame[2] = 8'd0;
        frame[3] = 8'd0;
        frame[4] = value[31:24];
        frame[5] = value[23:16];
        frame[6] = value[15:8];
        frame[7] = value[7:0];
        sum = 8'd0;
        for (int i = 0; i < 8; i++)
        begin
            sum = sum + frame[i];
        end
        frame[8] = sum;
    end

    // receiver state and job
    always_comb
    begin
        armed_next       = armed_reg;
        reply_count_next = reply_count_reg;
        reply_sum_next   = reply_sum_reg;
        held_status_next = held_status_reg;
        held_value_next  = held_value_reg;
        elapsed_next     = elapsed_reg;
        job_valid        = 1'b0;
        job.is_frame     = 1'b0;
        job.frame        = frame;
        job.kind         = tcfr_pkg::KIND_TIMEOUT;
        job.status       = 8'd0;
        job.value        = 32'd0;
        if (go)
        begin
            case (req_reg.opcode)
                tcfr_pkg::OP_SEND:
                begin
                    reply_count_next = 4'd0;
                    reply_sum_next   = 8'd0;
                    held_status_next = 8'd0;
                    held_value_next  = 32'd0;
                    elapsed_next     = 10'd0;
                    armed_next       = req_reg.read_back;
                    job_valid        = 1'b1;
                    job.is_frame     = 1'b1;
                    job.kind         = tcfr_pkg::KIND_TX;
                end
                tcfr_pkg::OP_RX_BYTE:
                begin
                    if (armed_reg)
                    begin
                        if (reply_count_reg < tcfr_pkg::SUM_LEN)
                        begin
                            if (reply_count_reg == tcfr_pkg::STATUS_POS)
                            begin
                                held_status_next = req_reg.rx_byte;
                            end
                            if (reply_count_reg >= tcfr_pkg::VALUE_POS)
                            begin
                                held_value_next = {held_value_reg[23:0], req_reg.rx_byte};
                            end
                            reply_sum_next   = reply_sum_reg + req_reg.rx_byte;
                            reply_count_next = reply_count_reg + 4'd1;
                        end
                        else
                        begin
                            if (req_reg.rx_byte != reply_sum_reg)
                            begin
                                job.kind = tcfr_pkg::KIND_CSUM_ERR;
                            end
                            else if (held_status_reg == cfg.ack_status_code)
                            begin
                                job.kind = tcfr_pkg::KIND_OK;
                            end
                            else
                            begin
                                job.kind = tcfr_pkg::KIND_NACK;
                            end
                            job.status       = held_status_reg;
                            job.value        = held_value_reg;
                            job_valid        = 1'b1;
                            armed_next       = 1'b0;
                            reply_count_next = 4'd0;
                        end
                    end
                end
                tcfr_pkg::OP_TICK:
                begin
                    if (armed_reg)
                    begin
                        if (elapsed_reg < tcfr_pkg::TICKS_MAX)
                        begin
                            elapsed_next = elapsed_reg + 10'd1;
                        end
                        if (elapsed_next >= cfg.timeout_ticks)
                        begin
                            armed_next = 1'b0;
                            job_valid  = 1'b1;
                            job.kind   = tcfr_pkg::KIND_TIMEOUT;
                        end
                    end
                end
                default:
                begin
                    armed_next = armed_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg       <= 1'b0;
            reply_count_reg <= 4'd0;
            reply_sum_reg   <= 8'd0;
            held_status_reg <= 8'd0;
            held_value_reg  <= 32'd0;
            elapsed_reg     <= 10'd0;
        end
        else
        begin
            armed_reg       <= armed_next;
            reply_count_reg <= reply_count_next;
            reply_sum_reg   <= reply_sum_next;
            held_status_reg <= held_status_next;
            held_value_reg  <= held_value_next;
            elapsed_reg     <= elapsed_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        reply_count_reg <= tcfr_pkg::SUM_LEN)
        else $error("reply count beyond eight");

    assert property (@(posedge clk) disable iff (!rst_n)
        !armed_reg |=> (reply_count_reg == 4'd0 && elapsed_reg == 10'd0) || !armed_reg)
        else $error("receiver armed without a fresh start");
`endif

endmodule

/* src/tcfr_serializer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcfr_serializer
// Job buffer and output register; drains a frame one byte per result.
// ----------------------------------------------------------------------------
module tcfr_serializer
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_valid,
    input  tcfr_pkg::job_t      job,
    output logic                job_free,
    tcfr_res_if.source          result
);

    logic            job_valid_reg;
    logic            job_valid_next;
    tcfr_pkg::job_t  job_reg;
    logic [3:0]      idx_reg;
    logic [3:0]      idx_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    tcfr_pkg::res_t  out_reg;
    tcfr_pkg::res_t  item;
    logic            job_last;
    logic            out_load;

    assign job_last = !job_reg.is_frame || (idx_reg == tcfr_pkg::LAST_IDX);
    assign out_load = job_valid_reg && (!out_valid_reg || result.ready);
    assign job_free = !job_valid_reg || (job_last && out_load);

    always_comb
    begin
        if (job_reg.is_frame)
        begin
            item.kind         = tcfr_pkg::KIND_TX;
            item.tx_byte      = job_reg.frame[idx_reg];
            item.tx_last      = (idx_reg == tcfr_pkg::LAST_IDX);
            item.reply_status = 8'd0;
            item.reply_value  = 32'sd0;
        end
        else
        begin
            item.kind         = job_reg.kind;
            item.tx_byte      = 8'd0;
            item.tx_last      = 1'b0;
            item.reply_status = job_reg.status;
            item.reply_value  = $signed(job_reg.value);
        end
    end

    always_comb
    begin
        job_valid_next = job_valid_reg;
        idx_next       = idx_reg;
        if (job_valid)
        begin
            job_valid_next = 1'b1;
            idx_next       = 4'd0;
        end
        else if (out_load && job_last)
        begin
            job_valid_next = 1'b0;
        end
        else if (out_load)
        begin
            idx_next = idx_reg + 4'd1;
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            job_valid_reg <= job_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_valid)
        begin
            job_reg <= job;
        end
        if (out_load)
        begin
            out_reg <= item;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg |-> idx_reg <= tcfr_pkg::LAST_IDX)
        else $error("frame index past the checksum byte");

    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid_reg && !job_reg.is_frame |-> idx_reg == 4'd0)
        else $error("reply job advanced its index");

    assert property (@(posedge clk) disable iff (!rst_n)
        job_valid |-> job_free)
        else $error("job handed over while the buffer is busy");
`endif

endmodule

/* src/tmcl_command_framer_reply_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmcl_command_framer_reply_checker
// Builds nine-byte motor command frames and checks nine-byte replies.
// ----------------------------------------------------------------------------
// A request goes through the request register, job buffer and output register.
// Throughput: one request per cycle while each yields at most one result and
// the output is not stalled; a send yields one frame byte per result and holds
// further requests until its checksum byte is loaded into the output register.
// Reset: rst_n clears all control state and loads the register defaults;
// no clearing pass is needed.
module tmcl_command_framer_reply_checker
(
    input  logic                              clk,
    input  logic                              rst_n,
    tcfr_req_if.sink                          request,
    tcfr_res_if.source                        result,
    input  logic                              cfg_write_en,
    input  logic [2:0]                        cfg_index,
    input  logic [tcfr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tcfr_pkg::cfg_t  cfg_reg;
    tcfr_pkg::cfg_t  cfg_next;
    logic            job_free;
    logic            job_valid;
    tcfr_pkg::job_t  job;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                tcfr_pkg::REG_CODE_RIGHT: cfg_next.code_rotate_right = cfg_data[7:0];
                tcfr_pkg::REG_CODE_LEFT:  cfg_next.code_rotate_left  = cfg_data[7:0];
                tcfr_pkg::REG_CODE_STOP:  cfg_next.code_stop         = cfg_data[7:0];
                tcfr_pkg::REG_ACK:        cfg_next.ack_status_code   = cfg_data[7:0];
                tcfr_pkg::REG_TIMEOUT:    cfg_next.timeout_ticks     = cfg_data[9:0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_rotate_right <= tcfr_pkg::RST_CODE_RIGHT;
            cfg_reg.code_rotate_left  <= tcfr_pkg::RST_CODE_LEFT;
            cfg_reg.code_stop         <= tcfr_pkg::RST_CODE_STOP;
            cfg_reg.ack_status_code   <= tcfr_pkg::RST_ACK;
            cfg_reg.timeout_ticks     <= tcfr_pkg::RST_TIMEOUT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    tcfr_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg       (cfg_reg),
        .job_free  (job_free),
        .job_valid (job_valid),
        .job       (job)
    );

    tcfr_serializer u_serializer
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job       (job),
        .job_free  (job_free),
        .result    (result)
    );

endmodule
